### hdl/skyb_pkg.sv
// ----------------------------------------------------------------------------
// skyb_pkg
// Shared types, constants and the sky colour table for the sky gradient
// phase blender.
// ----------------------------------------------------------------------------
`default_nettype none

package skyb_pkg;

    localparam int KEYFRAMES    = 4;
    localparam int CONTROL_ROWS = 4;
    localparam int MAX_HEIGHT   = 64;
    localparam int NUM_CH       = 3;

    localparam int PHASE_W  = 16;
    localparam int DT_W     = 10;
    localparam int HEIGHT_W = 7;
    localparam int ROWIDX_W = 6;
    localparam int GAIN_W   = 16;
    localparam int COLOUR_W = 8;
    localparam int KEY_W    = $clog2(KEYFRAMES);
    localparam int ROW_W    = $clog2(CONTROL_ROWS);
    localparam int CH_W     = $clog2(NUM_CH);
    localparam int KP_W     = PHASE_W + KEY_W;

    // row interpolation: ry = y * ROW_SPAN / (h - 1)
    localparam int ROW_SPAN = (CONTROL_ROWS - 1) * 65536;
    localparam int SPAN_W   = $clog2(ROW_SPAN + 1);
    localparam int DIVR_W   = $clog2(MAX_HEIGHT);
    localparam int DCNT_W   = $clog2(SPAN_W + 1);

    // shared multiplier operands
    localparam int MUL_A_W  = 26;
    localparam int MUL_B_W  = 17;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W + 1;
    localparam int BLEND_W  = 25;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_INC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_GAIN = 2'd2;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RST     = 7'd64;
    localparam logic [GAIN_W-1:0]   CYCLE_INC_RST  = 16'd3;
    localparam logic [GAIN_W-1:0]   TRACK_GAIN_RST = 16'd131;

    typedef struct packed {
        logic [DT_W-1:0]    dt_ms;
        logic               set_target;
        logic [PHASE_W-1:0] target_phase;
    } t_in;

    typedef struct packed {
        logic [ROWIDX_W-1:0] row_index;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic [PHASE_W-1:0]  current_phase;
        logic                last_row;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_DIV,
        S_DIVW,
        S_ROW,
        S_CA,
        S_CB,
        S_CC,
        S_CD,
        S_CE,
        S_EMIT
    } t_state;

    localparam logic [COLOUR_W-1:0] SKY_TABLE [KEYFRAMES][CONTROL_ROWS][NUM_CH] = '{
        '{'{8'd2,   8'd2,   8'd16 }, '{8'd6,   8'd7,   8'd34 },
          '{8'd14,  8'd13,  8'd52 }, '{8'd26,  8'd22,  8'd64 }},
        '{'{8'd24,  8'd20,  8'd62 }, '{8'd88,  8'd44,  8'd92 },
          '{8'd198, 8'd92,  8'd82 }, '{8'd255, 8'd152, 8'd92 }},
        '{'{8'd38,  8'd88,  8'd178}, '{8'd80,  8'd138, 8'd218},
          '{8'd138, 8'd188, 8'd238}, '{8'd198, 8'd222, 8'd248}},
        '{'{8'd16,  8'd12,  8'd48 }, '{8'd78,  8'd34,  8'd86 },
          '{8'd198, 8'd78,  8'd58 }, '{8'd255, 8'd118, 8'd58 }}
    };

endpackage

`default_nettype wire

### hdl/skyb_mul.sv
// ----------------------------------------------------------------------------
// skyb_mul
// Shared signed by unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module skyb_mul (
    input  logic                               i_clk,
    input  logic signed [skyb_pkg::MUL_A_W-1:0] i_a,
    input  logic        [skyb_pkg::MUL_B_W-1:0] i_b,
    output logic signed [skyb_pkg::MUL_P_W-1:0] o_p
);

    logic signed [skyb_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= skyb_pkg::MUL_P_W'(i_a) * skyb_pkg::MUL_P_W'($signed({1'b0, i_b}));
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

### hdl/skyb_div.sv
// ----------------------------------------------------------------------------
// skyb_div
// Restoring divider, one quotient bit per cycle: row span by (height - 1).
// ----------------------------------------------------------------------------
`default_nettype none

module skyb_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [skyb_pkg::DIVR_W-1:0]       i_divisor,
    output logic                              o_done,
    output logic [skyb_pkg::SPAN_W-1:0]       o_quot,
    output logic [skyb_pkg::DIVR_W-1:0]       o_rem
);

    logic                          r_busy;
    logic                          r_done;
    logic [skyb_pkg::DCNT_W-1:0]   r_cnt;
    logic [skyb_pkg::SPAN_W-1:0]   r_num;
    logic [skyb_pkg::SPAN_W-1:0]   r_quot;
    logic [skyb_pkg::DIVR_W-1:0]   r_rem;
    logic [skyb_pkg::DIVR_W-1:0]   r_div;

    logic [skyb_pkg::DIVR_W:0]     trial;
    logic                          ge;
    logic [skyb_pkg::DIVR_W-1:0]   n_rem;
    logic [skyb_pkg::DIVR_W:0]     diff;

    assign trial = {r_rem, r_num[skyb_pkg::SPAN_W-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};
    assign n_rem = ge ? diff[skyb_pkg::DIVR_W-1:0] : trial[skyb_pkg::DIVR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == skyb_pkg::DCNT_W'(skyb_pkg::SPAN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num  <= skyb_pkg::SPAN_W'(skyb_pkg::ROW_SPAN);
            r_quot <= '0;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_num  <= {r_num[skyb_pkg::SPAN_W-2:0], 1'b0};
            r_quot <= {r_quot[skyb_pkg::SPAN_W-2:0], ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |=> r_busy)
        else $error("divider did not start");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt < skyb_pkg::DCNT_W'(skyb_pkg::SPAN_W)))
        else $error("divider step count out of range");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_div != '0) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

### hdl/sky_gradient_phase_blender_core.sv
// sequence: phase update in P0 and P1, plus P2 and P3 when tracking, then the row-step division
// in DIV and DIVW when height > 1, then per row ROW, CA to CE per channel and EMIT, which
// waits for a free output register and loads it with the row result
// each colour channel steps through CA to CE, and CA, CB and CD drive the single shared 26x17 multiplier
// a new tick is taken once the last row of the previous one sits in the output register
// reset: synchronous active low; phase, target and tracking clear, registers to defaults
// ----------------------------------------------------------------------------
// sky_gradient_phase_blender_core
// Phase tracker and per-row bilinear sky colour blender under a small
// sequencer around one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module sky_gradient_phase_blender_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [skyb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [skyb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  skyb_pkg::t_in                       i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output skyb_pkg::t_out                      o_out
);

    skyb_pkg::t_state r_state, n_state;

    logic [skyb_pkg::HEIGHT_W-1:0]  r_height;
    logic [skyb_pkg::GAIN_W-1:0]    r_cycle_inc;
    logic [skyb_pkg::GAIN_W-1:0]    r_track_gain;

    logic [skyb_pkg::PHASE_W-1:0]   r_phase;
    logic [skyb_pkg::PHASE_W-1:0]   r_target;
    logic                           r_tracking;
    logic [skyb_pkg::DT_W-1:0]      r_dt;
    logic [skyb_pkg::MUL_B_W-1:0]   r_gain;
    logic signed [skyb_pkg::PHASE_W:0] r_diff;

    logic [skyb_pkg::KEY_W-1:0]     r_k1, r_k2;
    logic [skyb_pkg::PHASE_W-1:0]   r_kt;
    logic [skyb_pkg::ROWIDX_W-1:0]  r_hlast;
    logic [skyb_pkg::SPAN_W-1:0]    r_q0, r_acc_q;
    logic [skyb_pkg::DIVR_W-1:0]    r_r0, r_acc_r;
    logic [skyb_pkg::ROWIDX_W-1:0]  r_row;
    logic [skyb_pkg::ROW_W-1:0]     r_r1, r_r2;
    logic [skyb_pkg::PHASE_W-1:0]   r_rt;
    logic [skyb_pkg::CH_W-1:0]      r_ch;
    logic signed [skyb_pkg::BLEND_W-1:0] r_pa, r_a, r_b;
    logic [skyb_pkg::COLOUR_W-1:0]  r_col [skyb_pkg::NUM_CH];

    skyb_pkg::t_out                 r_out;
    logic                           r_out_valid;

    logic signed [skyb_pkg::MUL_A_W-1:0] mul_a;
    logic        [skyb_pkg::MUL_B_W-1:0] mul_b;
    logic signed [skyb_pkg::MUL_P_W-1:0] mul_p;
    logic                                div_start;
    logic                                div_done;
    logic [skyb_pkg::SPAN_W-1:0]         div_quot;
    logic [skyb_pkg::DIVR_W-1:0]         div_rem;

    logic                                in_accept;
    logic                                out_free;
    logic [skyb_pkg::HEIGHT_W-1:0]       h_sat;
    logic [skyb_pkg::HEIGHT_W-1:0]       h_less1;
    logic [skyb_pkg::KP_W-1:0]           kp;
    logic [skyb_pkg::KEY_W-1:0]          kp_int;
    logic [skyb_pkg::SPAN_W-17:0]        ry_int;
    logic [skyb_pkg::ROW_W-1:0]          row_r1;
    logic [skyb_pkg::COLOUR_W-1:0]       a0, a1, b0, b1;
    logic signed [skyb_pkg::COLOUR_W:0]  da, db;
    logic signed [skyb_pkg::PHASE_W+1:0] diff_raw, diff_wrap;
    logic signed [skyb_pkg::MUL_P_W-1:0] step_adj, step_v, blend_v;
    logic [skyb_pkg::DIVR_W:0]           sum_r;
    logic [skyb_pkg::DIVR_W:0]           sum_r_wrap;

    skyb_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    skyb_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (h_less1[skyb_pkg::DIVR_W-1:0]),
        .o_done    (div_done),
        .o_quot    (div_quot),
        .o_rem     (div_rem)
    );

    assign o_in_ready = (r_state == skyb_pkg::S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign h_sat   = (r_height > skyb_pkg::HEIGHT_W'(skyb_pkg::MAX_HEIGHT))
                     ? skyb_pkg::HEIGHT_W'(skyb_pkg::MAX_HEIGHT) : r_height;
    assign h_less1 = h_sat - 1'b1;

    assign kp     = skyb_pkg::KP_W'(r_phase) * skyb_pkg::KP_W'(skyb_pkg::KEYFRAMES);
    assign kp_int = kp[skyb_pkg::PHASE_W +: skyb_pkg::KEY_W];

    assign ry_int = r_acc_q[skyb_pkg::SPAN_W-1:16];
    assign row_r1 = (ry_int > (skyb_pkg::CONTROL_ROWS - 1))
                    ? skyb_pkg::ROW_W'(skyb_pkg::CONTROL_ROWS - 1)
                    : skyb_pkg::ROW_W'(ry_int);

    assign a0 = skyb_pkg::SKY_TABLE[r_k1][r_r1][r_ch];
    assign a1 = skyb_pkg::SKY_TABLE[r_k1][r_r2][r_ch];
    assign b0 = skyb_pkg::SKY_TABLE[r_k2][r_r1][r_ch];
    assign b1 = skyb_pkg::SKY_TABLE[r_k2][r_r2][r_ch];
    assign da = $signed({1'b0, a1}) - $signed({1'b0, a0});
    assign db = $signed({1'b0, b1}) - $signed({1'b0, b0});

    // shortest way round the circle
    assign diff_raw = $signed({2'b00, r_target}) - $signed({2'b00, r_phase});
    always_comb begin
        if (diff_raw > 18'sd32768) begin
            diff_wrap = diff_raw - 18'sd65536;
        end else if (diff_raw < -18'sd32768) begin
            diff_wrap = diff_raw + 18'sd65536;
        end else begin
            diff_wrap = diff_raw;
        end
    end

    // truncate toward zero
    assign step_adj = mul_p + (mul_p[skyb_pkg::MUL_P_W-1]
                      ? skyb_pkg::MUL_P_W'(65535) : skyb_pkg::MUL_P_W'(0));
    assign step_v   = step_adj >>> 16;

    assign blend_v  = (skyb_pkg::MUL_P_W'(r_a) <<< 16) + mul_p;

    assign sum_r      = {1'b0, r_acc_r} + {1'b0, r_r0};
    assign sum_r_wrap = sum_r - {1'b0, r_hlast};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skyb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        case (r_state)
            skyb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = skyb_pkg::S_P0;
                end
            end
            skyb_pkg::S_P0: begin
                mul_a   = r_tracking ? skyb_pkg::MUL_A_W'(r_track_gain)
                                     : skyb_pkg::MUL_A_W'(r_cycle_inc);
                mul_b   = skyb_pkg::MUL_B_W'(r_dt);
                n_state = skyb_pkg::S_P1;
            end
            skyb_pkg::S_P1: begin
                n_state = r_tracking ? skyb_pkg::S_P2 : skyb_pkg::S_DIV;
            end
            skyb_pkg::S_P2: begin
                mul_a   = skyb_pkg::MUL_A_W'(r_diff);
                mul_b   = r_gain;
                n_state = skyb_pkg::S_P3;
            end
            skyb_pkg::S_P3: begin
                n_state = skyb_pkg::S_DIV;
            end
            skyb_pkg::S_DIV: begin
                if (h_sat == '0) begin
                    n_state = skyb_pkg::S_IDLE;
                end else if (h_sat == skyb_pkg::HEIGHT_W'(1)) begin
                    n_state = skyb_pkg::S_ROW;
                end else begin
                    div_start = 1'b1;
                    n_state   = skyb_pkg::S_DIVW;
                end
            end
            skyb_pkg::S_DIVW: begin
                if (div_done) begin
                    n_state = skyb_pkg::S_ROW;
                end
            end
            skyb_pkg::S_ROW: begin
                n_state = skyb_pkg::S_CA;
            end
            skyb_pkg::S_CA: begin
                mul_a   = skyb_pkg::MUL_A_W'(da);
                mul_b   = skyb_pkg::MUL_B_W'(r_rt);
                n_state = skyb_pkg::S_CB;
            end
            skyb_pkg::S_CB: begin
                mul_a   = skyb_pkg::MUL_A_W'(db);
                mul_b   = skyb_pkg::MUL_B_W'(r_rt);
                n_state = skyb_pkg::S_CC;
            end
            skyb_pkg::S_CC: begin
                n_state = skyb_pkg::S_CD;
            end
            skyb_pkg::S_CD: begin
                mul_a   = skyb_pkg::MUL_A_W'(r_b) - skyb_pkg::MUL_A_W'(r_a);
                mul_b   = skyb_pkg::MUL_B_W'(r_kt);
                n_state = skyb_pkg::S_CE;
            end
            skyb_pkg::S_CE: begin
                n_state = (r_ch == skyb_pkg::CH_W'(skyb_pkg::NUM_CH - 1))
                          ? skyb_pkg::S_EMIT : skyb_pkg::S_CA;
            end
            skyb_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = (r_row == r_hlast) ? skyb_pkg::S_IDLE : skyb_pkg::S_ROW;
                end
            end
            default: begin
                n_state = skyb_pkg::S_IDLE;
            end
        endcase
    end

    // configuration and phase state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height     <= skyb_pkg::HEIGHT_RST;
            r_cycle_inc  <= skyb_pkg::CYCLE_INC_RST;
            r_track_gain <= skyb_pkg::TRACK_GAIN_RST;
            r_phase      <= '0;
            r_target     <= '0;
            r_tracking   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    skyb_pkg::CFG_HEIGHT:     r_height     <= i_cfg_data[skyb_pkg::HEIGHT_W-1:0];
                    skyb_pkg::CFG_CYCLE_INC:  r_cycle_inc  <= i_cfg_data[skyb_pkg::GAIN_W-1:0];
                    skyb_pkg::CFG_TRACK_GAIN: r_track_gain <= i_cfg_data[skyb_pkg::GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_accept && i_in.set_target) begin
                r_target   <= i_in.target_phase;
                r_tracking <= 1'b1;
            end
            if (r_state == skyb_pkg::S_P1 && !r_tracking) begin
                r_phase <= r_phase + mul_p[skyb_pkg::PHASE_W-1:0];
            end else if (r_state == skyb_pkg::S_P3) begin
                r_phase <= r_phase + step_v[skyb_pkg::PHASE_W-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            skyb_pkg::S_IDLE: begin
                r_dt <= i_in.dt_ms;
            end
            skyb_pkg::S_P1: begin
                r_gain <= (mul_p > skyb_pkg::MUL_P_W'(65536))
                          ? skyb_pkg::MUL_B_W'(65536) : mul_p[skyb_pkg::MUL_B_W-1:0];
                r_diff <= diff_wrap[skyb_pkg::PHASE_W:0];
            end
            skyb_pkg::S_DIV: begin
                r_k1    <= kp_int;
                r_k2    <= (kp_int == skyb_pkg::KEY_W'(skyb_pkg::KEYFRAMES - 1))
                           ? '0 : kp_int + 1'b1;
                r_kt    <= kp[skyb_pkg::PHASE_W-1:0];
                r_hlast <= h_less1[skyb_pkg::ROWIDX_W-1:0];
                r_q0    <= '0;
                r_r0    <= '0;
                r_acc_q <= '0;
                r_acc_r <= '0;
                r_row   <= '0;
            end
            skyb_pkg::S_DIVW: begin
                if (div_done) begin
                    r_q0 <= div_quot;
                    r_r0 <= div_rem;
                end
            end
            skyb_pkg::S_ROW: begin
                r_r1 <= row_r1;
                r_r2 <= (row_r1 == skyb_pkg::ROW_W'(skyb_pkg::CONTROL_ROWS - 1))
                        ? row_r1 : row_r1 + 1'b1;
                r_rt <= r_acc_q[skyb_pkg::PHASE_W-1:0];
                r_ch <= '0;
            end
            skyb_pkg::S_CB: begin
                r_pa <= mul_p[skyb_pkg::BLEND_W-1:0];
            end
            skyb_pkg::S_CC: begin
                r_a <= $signed({1'b0, a0, 16'h0000}) + r_pa;
                r_b <= $signed({1'b0, b0, 16'h0000}) + mul_p[skyb_pkg::BLEND_W-1:0];
            end
            skyb_pkg::S_CE: begin
                r_col[r_ch] <= blend_v[skyb_pkg::MUL_P_W-1] ? '0 : blend_v[39:32];
                r_ch        <= r_ch + 1'b1;
            end
            skyb_pkg::S_EMIT: begin
                if (out_free) begin
                    r_row <= r_row + 1'b1;
                    if (sum_r >= {1'b0, r_hlast}) begin
                        r_acc_r <= sum_r_wrap[skyb_pkg::DIVR_W-1:0];
                        r_acc_q <= r_acc_q + r_q0 + 1'b1;
                    end else begin
                        r_acc_r <= sum_r[skyb_pkg::DIVR_W-1:0];
                        r_acc_q <= r_acc_q + r_q0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == skyb_pkg::S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == skyb_pkg::S_EMIT && out_free) begin
            r_out.row_index     <= r_row;
            r_out.red           <= r_col[0];
            r_out.green         <= r_col[1];
            r_out.blue          <= r_col[2];
            r_out.current_phase <= r_phase;
            r_out.last_row      <= (r_row == r_hlast);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skyb_pkg::S_EMIT) |-> (r_row <= r_hlast))
        else $error("row counter past last row");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skyb_pkg::S_ROW && r_hlast != '0) |-> (r_acc_r < r_hlast))
        else $error("row step remainder not below divisor");

    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skyb_pkg::S_ROW) |-> (r_acc_q <= skyb_pkg::SPAN_W'(skyb_pkg::ROW_SPAN)))
        else $error("row position beyond last control row");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skyb_pkg::S_EMIT && out_free) |=> r_out_valid)
        else $error("row result not loaded into output register");

endmodule

`default_nettype wire
